[hdl/rts_pkg.sv]
// Package for the RGB to spectrum sample block: widths, basis codes, knot tables
// and the resampled basis ROM built at elaboration. No dependencies.

package rts_pkg;

  localparam int unsigned SAMPLES  = 35;
  localparam int unsigned MIN_NM   = 380;
  localparam int unsigned STEP_NM  = 10;

  localparam int unsigned CH_W     = 16;
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned WORD_W   = 16;
  localparam int unsigned PROD_W   = CH_W + WORD_W;
  localparam int unsigned SUM_W    = PROD_W + 2;
  localparam int unsigned FRAC_SH  = 14;
  localparam int unsigned POWER_W  = 18;
  localparam int unsigned ROM_AW   = $clog2(SAMPLES);
  localparam logic [POWER_W-1:0] POWER_MAX = '1;

  localparam int unsigned KNOTS    = 10;
  localparam int unsigned BASES    = 7;

  typedef enum logic [2:0] {
    B_WHITE   = 3'd0,
    B_CYAN    = 3'd1,
    B_MAGENTA = 3'd2,
    B_YELLOW  = 3'd3,
    B_RED     = 3'd4,
    B_GREEN   = 3'd5,
    B_BLUE    = 3'd6
  } basis_e;

  typedef logic [BASES-1:0][SAMPLES-1:0][WORD_W-1:0] rom_t;

  typedef struct packed {
    logic [CH_W-1:0]   lo;
    logic [CH_W-1:0]   w2;
    logic [CH_W-1:0]   w3;
    logic [WORD_W-1:0] white;
    logic [WORD_W-1:0] sec;
    logic [WORD_W-1:0] pri;
  } sel_t;

  // knot wavelengths in 0.01 nm
  localparam longint KNOT_CNM [KNOTS] = '{
    38000, 41770, 45555, 49333, 53111, 56888, 60666, 64444, 68222, 72000
  };

  // knot spacing; first entry unused
  localparam longint KNOT_DX [KNOTS] = '{
    1, 3770, 3785, 3778, 3778, 3777, 3778, 3778, 3778, 3778
  };

  localparam longint BASIS_Q15 [BASES][KNOTS] = '{
    '{32768, 32768, 32765, 32745, 32742, 32761, 32768, 32768, 32768, 32768},
    '{31818, 30887, 32791, 32791, 32791, 32791,  5125,     0,     0,     0},
    '{32768, 32768, 31736,  7304,     0,  1501, 27424, 32768, 32768, 32634},
    '{    3,     0,  3565, 21794, 32768, 32768, 32755, 31411, 31736, 32244},
    '{ 3316,  1688,     0,     0,     0,     0, 27279, 33256, 33256, 33256},
    '{    0,     0,   895, 26008, 32768, 30861,  5633,     0,     0,    82},
    '{32768, 32768, 29216, 10889,     0,     0,    10,  1209,  1583,  1625}
  };

  function automatic rom_t build_rom();
    rom_t   rom;
    longint w;
    longint num;
    int     k;
    rom = '0;
    for (int i = 0; i < int'(SAMPLES); i++) begin
      w = (longint'(MIN_NM) + longint'(STEP_NM) * longint'(i)) * 100;
      if (w >= KNOT_CNM[0] && w <= KNOT_CNM[KNOTS-1]) begin
        k = KNOTS - 1;
        for (int j = KNOTS - 1; j >= 1; j--) begin
          if (w <= KNOT_CNM[j]) k = j;
        end
        for (int b = 0; b < int'(BASES); b++) begin
          if (w == KNOT_CNM[0]) begin
            rom[b][i] = WORD_W'(BASIS_Q15[b][0]);
          end else begin
            num = BASIS_Q15[b][k-1] * (KNOT_CNM[k] - w) + BASIS_Q15[b][k] * (w - KNOT_CNM[k-1]);
            rom[b][i] = WORD_W'((num + KNOT_DX[k] / 2) / KNOT_DX[k]);
          end
        end
      end
    end
    return rom;
  endfunction

  localparam rom_t ROM = build_rom();

endpackage

[hdl/rts_select.sv]
// Channel ordering, weight forming and basis ROM lookup, registered.
// Depends on rts_pkg.

module rts_select (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [rts_pkg::CH_W-1:0]   red_i,
  input  logic [rts_pkg::CH_W-1:0]   green_i,
  input  logic [rts_pkg::CH_W-1:0]   blue_i,
  input  logic [rts_pkg::IDX_W-1:0]  wave_index_i,
  output logic                       valid_o,
  output rts_pkg::sel_t              sel_o
);

  logic                      valid_q;
  rts_pkg::sel_t             sel_d, sel_q;
  rts_pkg::basis_e           sec, pri;
  logic                      in_grid;
  logic [rts_pkg::ROM_AW-1:0] addr;

  always_comb begin
    sel_d = '0;
    sec   = rts_pkg::B_CYAN;
    pri   = rts_pkg::B_BLUE;
    if (red_i <= green_i && red_i <= blue_i) begin
      sel_d.lo = red_i;
      sec      = rts_pkg::B_CYAN;
      if (green_i <= blue_i) begin
        sel_d.w2 = green_i - red_i;
        sel_d.w3 = blue_i - green_i;
        pri      = rts_pkg::B_BLUE;
      end else begin
        sel_d.w2 = blue_i - red_i;
        sel_d.w3 = green_i - blue_i;
        pri      = rts_pkg::B_GREEN;
      end
    end else if (green_i <= red_i && green_i <= blue_i) begin
      sel_d.lo = green_i;
      sec      = rts_pkg::B_MAGENTA;
      if (red_i <= blue_i) begin
        sel_d.w2 = red_i - green_i;
        sel_d.w3 = blue_i - red_i;
        pri      = rts_pkg::B_BLUE;
      end else begin
        sel_d.w2 = blue_i - green_i;
        sel_d.w3 = red_i - blue_i;
        pri      = rts_pkg::B_RED;
      end
    end else begin
      sel_d.lo = blue_i;
      sec      = rts_pkg::B_YELLOW;
      if (red_i <= green_i) begin
        sel_d.w2 = red_i - blue_i;
        sel_d.w3 = green_i - red_i;
        pri      = rts_pkg::B_GREEN;
      end else begin
        sel_d.w2 = green_i - blue_i;
        sel_d.w3 = red_i - green_i;
        pri      = rts_pkg::B_RED;
      end
    end

    in_grid = int'(wave_index_i) < int'(rts_pkg::SAMPLES);
    addr    = wave_index_i[rts_pkg::ROM_AW-1:0];
    if (in_grid) begin
      sel_d.white = rts_pkg::ROM[rts_pkg::B_WHITE][addr];
      sel_d.sec   = rts_pkg::ROM[sec][addr];
      sel_d.pri   = rts_pkg::ROM[pri][addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sel_q <= sel_d;
    end
  end

  assign valid_o = valid_q;
  assign sel_o   = sel_q;

endmodule

[hdl/rts_combine.sv]
// Weighted sum of the three basis words: registered products, then sum,
// truncate and saturate into the result register. Depends on rts_pkg.

module rts_combine (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  rts_pkg::sel_t                sel_i,
  output logic                         valid_o,
  output logic [rts_pkg::POWER_W-1:0]  power_o
);

  localparam int unsigned SH_W = rts_pkg::SUM_W - rts_pkg::FRAC_SH;

  logic                          prod_valid_q, out_valid_q;
  logic [rts_pkg::PROD_W-1:0]    p_lo_q, p_sec_q, p_pri_q;
  logic [rts_pkg::SUM_W-1:0]     sum;
  logic [SH_W-1:0]               shifted;
  logic [rts_pkg::POWER_W-1:0]   power_d, power_q;

  always_comb begin
    sum = rts_pkg::SUM_W'(p_lo_q) + rts_pkg::SUM_W'(p_sec_q) + rts_pkg::SUM_W'(p_pri_q);
    shifted = sum[rts_pkg::SUM_W-1:rts_pkg::FRAC_SH];
    if (shifted > SH_W'(rts_pkg::POWER_MAX)) begin
      power_d = rts_pkg::POWER_MAX;
    end else begin
      power_d = shifted[rts_pkg::POWER_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else if (en_i) begin
      prod_valid_q <= valid_i;
      out_valid_q  <= prod_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_lo_q  <= sel_i.lo * sel_i.white;
      p_sec_q <= sel_i.w2 * sel_i.sec;
      p_pri_q <= sel_i.w3 * sel_i.pri;
      power_q <= power_d;
    end
  end

  assign valid_o = out_valid_q;
  assign power_o = power_q;

endmodule

[hdl/rgb_to_spectrum_sample_top.sv]
// Smits RGB to spectrum conversion, one spectral sample per transfer.
// Three pipeline stages: ordering and basis ROM lookup, the three products,
// then sum with truncation and saturation into the output register. One item
// enters every cycle while the output side does not stall. The result of an
// input transfer passes through the select register, the product registers
// and the output register, where it becomes valid. A stall on the output holds
// the whole pipeline, and tready follows the output register's state.
// Depends on rts_pkg, rts_select and rts_combine.

module rgb_to_spectrum_sample_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // red[15:0], green[31:16], blue[47:32], wave_index[53:48]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // power[17:0]
);

  logic                        en;
  logic                        sel_valid;
  rts_pkg::sel_t               sel;
  logic [rts_pkg::POWER_W-1:0] power;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  rts_select u_select (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (s_axis_tvalid),
    .red_i        (s_axis_tdata[15:0]),
    .green_i      (s_axis_tdata[31:16]),
    .blue_i       (s_axis_tdata[47:32]),
    .wave_index_i (s_axis_tdata[53:48]),
    .valid_o      (sel_valid),
    .sel_o        (sel)
  );

  rts_combine u_combine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sel_valid),
    .sel_i   (sel),
    .valid_o (m_axis_tvalid),
    .power_o (power)
  );

  assign m_axis_tdata = {{(24 - rts_pkg::POWER_W){1'b0}}, power};

`ifndef NO_ASSERTIONS
  a_ready_follows_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output register state");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[23:18] == 6'd0)
    else $error("output padding bits not zero");

  a_stall_holds_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sel_valid && !en) |=> (sel_valid && $stable(sel)))
    else $error("select stage changed during stall");

  a_rise_needs_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!sel_valid && en) |=> ##1 (!m_axis_tvalid || !$past(en)))
    else $error("result appeared without a preceding item");
`endif

endmodule
